// ----- hw/rtl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants for the line pixel stepper
// Word kinds, configuration register map, reset values and default widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lps_pkg;

    // default coordinate width
    localparam int LPS_COORD_BITS = 10;

    // display size registers
    localparam int LPS_DIM_BITS = 11;
    localparam logic [LPS_DIM_BITS-1:0] LPS_WIDTH_RESET  = 11'd320;
    localparam logic [LPS_DIM_BITS-1:0] LPS_HEIGHT_RESET = 11'd480;

    // configuration port
    localparam int LPS_CFG_IDX_W = 2;

    // depth of the queue between front and back
    localparam int LPS_QUEUE_DEPTH = 2;

    localparam int LPS_COLOR_BITS = 24;

    typedef enum logic [LPS_CFG_IDX_W-1:0] {
        LPS_REG_DISPLAY_WIDTH  = 2'd0,
        LPS_REG_DISPLAY_HEIGHT = 2'd1
    } lps_reg_t;

    typedef enum logic {
        LPS_KIND_START = 1'b0,
        LPS_KIND_STEP  = 1'b1
    } lps_kind_t;

    typedef struct packed {
        logic [LPS_DIM_BITS-1:0] width;
        logic [LPS_DIM_BITS-1:0] height;
    } lps_cfg_t;

endpackage

// ----- hw/rtl/line_pixel_stepper.sv -----
// Path: a step word is first written into the queue, then popped by the stepper,
//   which loads its pixel into the output register (popping waits while it stalls).
// Throughput: one word per clock while out_ready is high; the stepper handles one queue
//   entry per cycle and the output register lets the next pixel load as one is taken.
// Reset: asynchronous, active low; clears the queue, the line and the output,
//   and sets the display size to 320 by 480. No clearing pass is needed.
// ----------------------------------------------------------------------------
// line_pixel_stepper: Bresenham line rasterizer
// Front classifies input words, a short queue decouples it from the stepper
// that walks the line and emits one pixel word per step word while a line is active.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_pixel_stepper #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lps_pkg::LPS_CFG_IDX_W-1:0]  cfg_index,
    input  logic [lps_pkg::LPS_DIM_BITS-1:0]   cfg_data,

    // input word channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [COORD_BITS-1:0]              x_start,
    input  logic [COORD_BITS-1:0]              y_start,
    input  logic [COORD_BITS-1:0]              x_end,
    input  logic [COORD_BITS-1:0]              y_end,
    input  logic [lps_pkg::LPS_COLOR_BITS-1:0] pixel_color_in,

    // pixel word channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [COORD_BITS-1:0]              pixel_x,
    output logic [COORD_BITS-1:0]              pixel_y,
    output logic [lps_pkg::LPS_COLOR_BITS-1:0] pixel_color,
    output logic                               visible,
    output logic                               last
);

    import lps_pkg::*;

    // queue entry: kind, both endpoints, spans, directions, initial error, color
    localparam int ENT_W = 1 + 6*COORD_BITS + 2 + (COORD_BITS + 2) + LPS_COLOR_BITS;

    lps_cfg_t          cfg_reg, cfg_next;
    logic [ENT_W-1:0]  push_entry;
    logic [ENT_W-1:0]  pop_entry;
    logic              pop_valid;
    logic              pop_ready;

    // Display size registers. Writes are always taken; the contract keeps
    // them to idle periods, so the stepper reads them without any shadowing.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (lps_reg_t'(cfg_index))
                LPS_REG_DISPLAY_WIDTH:  cfg_next.width  = cfg_data;
                LPS_REG_DISPLAY_HEIGHT: cfg_next.height = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= LPS_WIDTH_RESET;
            cfg_reg.height <= LPS_HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: tag the word and precompute start values in the accept cycle.
    lps_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .mode           (mode),
        .x_start        (x_start),
        .y_start        (y_start),
        .x_end          (x_end),
        .y_end          (y_end),
        .pixel_color_in (pixel_color_in),
        .entry          (push_entry)
    );

    // Queue: in_ready is simply "queue has room", so input never waits on
    // the output side unless the queue actually fills.
    lps_queue #(
        .WIDTH (ENT_W),
        .DEPTH (LPS_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    // Back: line state, error-term step and the pixel output register.
    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .visible     (visible),
        .last        (last)
    );

endmodule

// ----- hw/rtl/lps_front.sv -----
// ----------------------------------------------------------------------------
// lps_front: input classifier
// Tags each word as start or step and precomputes spans, directions and the
// initial error term of a start word, packed as one queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_front #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic                              mode,
    input  logic [COORD_BITS-1:0]             x_start,
    input  logic [COORD_BITS-1:0]             y_start,
    input  logic [COORD_BITS-1:0]             x_end,
    input  logic [COORD_BITS-1:0]             y_end,
    input  logic [lps_pkg::LPS_COLOR_BITS-1:0] pixel_color_in,
    output logic [1 + 6*COORD_BITS + 2 + (COORD_BITS+2) + lps_pkg::LPS_COLOR_BITS - 1:0] entry
);

    import lps_pkg::*;

    localparam int ERR_W = COORD_BITS + 2;

    lps_kind_t             kind;
    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;
    logic                  dir_x_neg;
    logic                  dir_y_neg;
    logic [ERR_W-1:0]      err_init;

    always_comb
    begin
        kind      = (mode == 1'b0) ? LPS_KIND_START : LPS_KIND_STEP;
        span_x    = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
        span_y    = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
        dir_x_neg = !(x_start < x_end);
        dir_y_neg = !(y_start < y_end);
        err_init  = ERR_W'(span_x) - ERR_W'(span_y);
    end

    assign entry = {kind, x_start, y_start, x_end, y_end, span_x, span_y,
                    dir_x_neg, dir_y_neg, err_init, pixel_color_in};

endmodule

// ----- hw/rtl/lps_queue.sv -----
// ----------------------------------------------------------------------------
// lps_queue: short FIFO between front and back
// Register-based ring buffer, push and pop in the same cycle allowed while neither empty nor full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lps_pkg::LPS_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    import lps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/lps_back.sv -----
// ----------------------------------------------------------------------------
// lps_back: line stepper
// Holds the active line, executes queued words and drives the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lps_back #(
    parameter int COORD_BITS = lps_pkg::LPS_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lps_pkg::lps_cfg_t                 cfg,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  logic [1 + 6*COORD_BITS + 2 + (COORD_BITS+2) + lps_pkg::LPS_COLOR_BITS - 1:0] pop_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [COORD_BITS-1:0]             pixel_x,
    output logic [COORD_BITS-1:0]             pixel_y,
    output logic [lps_pkg::LPS_COLOR_BITS-1:0] pixel_color,
    output logic                              visible,
    output logic                              last
);

    import lps_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int ERR_W = C + 2;
    localparam int SUM_W = C + 3;
    localparam int CMP_W = (C > LPS_DIM_BITS) ? C : LPS_DIM_BITS;

    // entry fields
    logic                      e_kind;
    logic [C-1:0]              e_x0, e_y0, e_x1, e_y1, e_sx, e_sy;
    logic                      e_dxn, e_dyn;
    logic [ERR_W-1:0]          e_err;
    logic [LPS_COLOR_BITS-1:0] e_color;

    assign {e_kind, e_x0, e_y0, e_x1, e_y1, e_sx, e_sy,
            e_dxn, e_dyn, e_err, e_color} = pop_data;

    logic [C-1:0]              cur_x_reg, cur_x_next;
    logic [C-1:0]              cur_y_reg, cur_y_next;
    logic [C-1:0]              tgt_x_reg, tgt_x_next;
    logic [C-1:0]              tgt_y_reg, tgt_y_next;
    logic [C-1:0]              span_x_reg, span_x_next;
    logic [C-1:0]              span_y_reg, span_y_next;
    logic                      dxn_reg, dxn_next;
    logic                      dyn_reg, dyn_next;
    logic [ERR_W-1:0]          err_reg, err_next;
    logic                      active_reg, active_next;
    logic [LPS_COLOR_BITS-1:0] color_reg, color_next;
    logic                      out_valid_reg, out_valid_next;

    logic [C-1:0]              out_x_reg, out_y_reg;
    logic [LPS_COLOR_BITS-1:0] out_color_reg;
    logic                      out_vis_reg, out_last_reg;

    logic                      pop_fire;
    logic                      is_start;
    logic                      emit;
    logic                      is_last;
    logic                      is_vis;
    logic                      move_x, move_y;
    logic signed [SUM_W-1:0]   err_ext, e2, sx_s, sy_s, err_sum;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop_fire  = pop_valid && pop_ready;
    assign is_start  = (e_kind == LPS_KIND_START);
    assign emit      = pop_fire && !is_start && active_reg;
    assign is_last   = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign is_vis    = (CMP_W'(cur_x_reg) < CMP_W'(cfg.width)) &&
                       (CMP_W'(cur_y_reg) < CMP_W'(cfg.height));

    // error-term step: x moves on e2 > -dy, y moves on e2 < dx
    always_comb
    begin
        err_ext = signed'({err_reg[ERR_W-1], err_reg});
        e2      = err_ext <<< 1;
        sx_s    = signed'({3'b000, span_x_reg});
        sy_s    = signed'({3'b000, span_y_reg});
        move_x  = (e2 > -sy_s);
        move_y  = (e2 < sx_s);
        err_sum = err_ext - (move_x ? sy_s : '0) + (move_y ? sx_s : '0);
    end

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        dxn_next       = dxn_reg;
        dyn_next       = dyn_reg;
        err_next       = err_reg;
        active_next    = active_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop_fire && is_start)
        begin
            cur_x_next  = e_x0;
            cur_y_next  = e_y0;
            tgt_x_next  = e_x1;
            tgt_y_next  = e_y1;
            span_x_next = e_sx;
            span_y_next = e_sy;
            dxn_next    = e_dxn;
            dyn_next    = e_dyn;
            err_next    = e_err;
            color_next  = e_color;
            active_next = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = err_sum[ERR_W-1:0];
                if (move_x)
                begin
                    cur_x_next = dxn_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                end
                if (move_y)
                begin
                    cur_y_next = dyn_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            dxn_reg       <= 1'b0;
            dyn_reg       <= 1'b0;
            err_reg       <= '0;
            active_reg    <= 1'b0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            dxn_reg       <= dxn_next;
            dyn_reg       <= dyn_next;
            err_reg       <= err_next;
            active_reg    <= active_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_color_reg <= color_reg;
            out_vis_reg   <= is_vis;
            out_last_reg  <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign visible     = out_vis_reg;
    assign last        = out_last_reg;

`ifndef SYNTH
    // a waiting pixel is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !pop_ready)
        else $error("pixel register reloaded while stalled");

    // the endpoint pixel closes the line
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        emit && is_last |=> !active_reg)
        else $error("line still active after last pixel");

    // a step word with no active line leaves the stepper untouched
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && !is_start && !active_reg |=>
            !active_reg && $stable(cur_x_reg) && $stable(cur_y_reg))
        else $error("idle step changed line state");
`endif

endmodule
